### rtl/core/epsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_pkg
// Shared constants, types and helpers for the exact pattern stream matcher.
// ----------------------------------------------------------------------------
package epsm_pkg;

	// sizing
	localparam int MAX_PATTERN = 64;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int BYTE_W      = 8;
	localparam int POS_W       = 32;
	localparam int CFG_W       = 7;
	localparam int OP_W        = 2;
	localparam int INDEX_W     = 6;
	// width that holds both a pattern index and the pattern depth
	localparam int CW          = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;

	// operation codes of an input beat
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	// control shared by every cell of the chain
	typedef struct packed {
		logic shift;   // take the text byte of the left neighbor
		logic clear;   // restart: drop held text
		logic rotate;  // take the pattern byte of the right neighbor
	} epsm_cell_ctl_t;

	// length register clamped to 1..MAX_PATTERN
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] len);
		logic [LEN_W-1:0] res;
		if (len == '0) begin
			res = LEN_W'(1);
		end else if (32'(len) > 32'(MAX_PATTERN)) begin
			res = LEN_W'(MAX_PATTERN);
		end else begin
			res = LEN_W'(len);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### rtl/core/exact_pattern_stream_matcher_core.sv
// An accepted text beat passes the stage 1 register, then the output register.
// Throughput: one beat per cycle, any op, while the output keeps up and no realign runs.
// A pattern_length write realigns the pattern chain one cell per cycle, with
// in_ready low while it lasts; equal effective length costs nothing.
// Reset (arst_n low): length 1, position, count and fill cleared, no beats held.
// ----------------------------------------------------------------------------
// exact_pattern_stream_matcher_core
// Streaming exact pattern matcher built as a row of compare cells: text
// shifts through the row, each cell checks its byte against the aligned
// pattern byte, and a full window hit reports start position and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module exact_pattern_stream_matcher_core import epsm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_wr_en,
	input  wire logic [CFG_W-1:0]   cfg_wr_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [INDEX_W-1:0] index,
	input  wire logic [BYTE_W-1:0]  value,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    is_match,
	output logic [POS_W-1:0]        match_start,
	output logic [POS_W-1:0]        match_count
);

	logic [CFG_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_eff;
	logic [IDX_W-1:0]  base_q;
	logic [IDX_W-1:0]  target_base;
	logic              realign;
	logic [LEN_W-1:0]  fill_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  count_q;
	logic [POS_W-1:0]  count_next;
	logic              s1_valid_q;
	logic [POS_W-1:0]  pos_s1;
	logic              s1_adv;
	logic              out_valid_q;
	logic              out_match_q;
	logic [POS_W-1:0]  out_start_q;
	logic [POS_W-1:0]  out_count_q;
	logic              accept;
	logic              text_acc;
	logic              load_acc;
	logic              restart_acc;
	logic              hit;
	logic [POS_W-1:0]  start_calc;
	logic [CW-1:0]     idx_ext;
	logic [CW-1:0]     base_ext;
	logic [CW-1:0]     wr_pos;
	logic              idx_ok;
	epsm_cell_ctl_t    cell_ctl;
	logic [MAX_PATTERN-1:0] wr_sel;
	logic [MAX_PATTERN-1:0] ok_vec;
	logic [BYTE_W-1:0] text_chain [MAX_PATTERN];
	logic [BYTE_W-1:0] pat_chain  [MAX_PATTERN];

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	assign len_eff     = eff_len(len_q);
	assign target_base = IDX_W'(len_eff - LEN_W'(1));
	assign realign     = (base_q != target_base);

	// alignment: cell k holds pattern byte (base_q - k) mod MAX_PATTERN
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (realign) begin
			base_q <= (base_q == '0) ? IDX_W'(MAX_PATTERN - 1) : base_q - IDX_W'(1);
		end
	end

	// handshake
	assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready    = !realign && !(s1_valid_q && !s1_adv);
	assign accept      = in_valid && in_ready;
	assign text_acc    = accept && (op == OP_TEXT);
	assign load_acc    = accept && (op == OP_LOAD);
	assign restart_acc = accept && (op == OP_RESTART);

	// target cell of a pattern load
	assign idx_ext  = CW'(index);
	assign base_ext = CW'(base_q);
	assign idx_ok   = idx_ext < CW'(MAX_PATTERN);
	always_comb begin
		if (idx_ext <= base_ext) begin
			wr_pos = base_ext - idx_ext;
		end else begin
			wr_pos = base_ext + CW'(MAX_PATTERN) - idx_ext;
		end
	end

	assign cell_ctl.shift  = text_acc;
	assign cell_ctl.clear  = restart_acc;
	assign cell_ctl.rotate = realign;

	// chain of cells
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		localparam logic [LEN_W-1:0] K_LEN = LEN_W'(k);
		localparam logic [CW-1:0]    K_POS = CW'(k);
		logic [BYTE_W-1:0] text_src;

		if (k == 0) begin : g_head
			assign text_src = value;
		end else begin : g_body
			assign text_src = text_chain[k-1];
		end

		assign wr_sel[k] = load_acc && idx_ok && (wr_pos == K_POS);

		epsm_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.wr_sel   (wr_sel[k]),
			.wr_data  (value),
			.text_in  (text_src),
			.pat_in   (pat_chain[(k + 1) % MAX_PATTERN]),
			.care     (K_LEN < len_eff),
			.text_out (text_chain[k]),
			.pat_out  (pat_chain[k]),
			.ok       (ok_vec[k])
		);
	end

	// stream position, fill and stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			fill_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (restart_acc) begin
				pos_q  <= '0;
				fill_q <= '0;
			end else if (text_acc) begin
				pos_q <= pos_q + POS_W'(1);
				if (fill_q != LEN_W'(MAX_PATTERN)) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end
			if (text_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// position of the byte in stage 1
	always_ff @(posedge clk) begin
		if (text_acc) begin
			pos_s1 <= pos_q;
		end
	end

	// window decision
	assign hit        = s1_valid_q && (fill_q >= len_eff) && (&ok_vec);
	assign count_next = (hit && (count_q != '1)) ? count_q + POS_W'(1) : count_q;
	assign start_calc = pos_s1 - {{(POS_W-LEN_W){1'b0}}, len_eff - LEN_W'(1)};

	// running match count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (restart_acc) begin
			count_q <= '0;
		end else if (s1_adv) begin
			count_q <= count_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_match_q <= hit;
			out_start_q <= hit ? start_calc : '0;
			out_count_q <= count_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_match    = out_match_q;
	assign match_start = out_start_q;
	assign match_count = out_count_q;

endmodule
`default_nettype wire

### rtl/core/epsm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_cell
// One cell of the matcher chain: holds one recent text byte and the pattern
// byte aligned to it, and compares the two.
// ----------------------------------------------------------------------------
module epsm_cell import epsm_pkg::*; (
	input  wire logic              clk,
	input  wire epsm_cell_ctl_t    ctl,
	input  wire logic              wr_sel,
	input  wire logic [BYTE_W-1:0] wr_data,
	input  wire logic [BYTE_W-1:0] text_in,
	input  wire logic [BYTE_W-1:0] pat_in,
	input  wire logic              care,
	output logic      [BYTE_W-1:0] text_out,
	output logic      [BYTE_W-1:0] pat_out,
	output logic                   ok
);

	logic [BYTE_W-1:0] text_q;
	logic [BYTE_W-1:0] pat_q;

	// text shift line stage
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			text_q <= '0;
		end else if (ctl.shift) begin
			text_q <= text_in;
		end
	end

	// aligned pattern byte: realignment step or direct load
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			pat_q <= pat_in;
		end else if (wr_sel) begin
			pat_q <= wr_data;
		end
	end

	// cells beyond the active length always agree
	assign ok       = !care || (text_q == pat_q);
	assign text_out = text_q;
	assign pat_out  = pat_q;

endmodule
`default_nettype wire

### rtl/core/epsm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_checker
// Port-level checks on the result channel of the matcher core.
// ----------------------------------------------------------------------------
module epsm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        is_match,
	input wire logic [31:0] match_start,
	input wire logic [31:0] match_count
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_match)
			&& $stable(match_start) && $stable(match_count))
		else $error("result beat changed while stalled");

	// no start position without a match
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_match |-> match_start == 32'd0)
		else $error("start position set on a non-match beat");

	// a match always counts
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_match |-> match_count != 32'd0)
		else $error("match reported with zero count");

endmodule

bind exact_pattern_stream_matcher_core epsm_checker u_epsm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.is_match    (is_match),
	.match_start (match_start),
	.match_count (match_count)
);
`default_nettype wire
